// ===== src/bitmap_font_text_renderer_top_macros.svh =====
// Assertion helpers used by the port checker.
`ifndef BITMAP_FONT_TEXT_RENDERER_TOP_MACROS_SVH
`define BITMAP_FONT_TEXT_RENDERER_TOP_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define BFTR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bftr port check failed");

// Next-cycle implication, held off while reset is low.
`define BFTR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bftr port check failed");

`endif

// ===== src/bftr_pkg.sv =====
package bftr_pkg;

    // Operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_CURSOR = 2'd1,
        OP_DRAW   = 2'd2,
        OP_INIT   = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_FONT_WIDTH = 2'd0;
    localparam logic [1:0] CFG_FONT_PAGES = 2'd1;
    localparam logic [1:0] CFG_FIRST_CODE = 2'd2;

    localparam logic [3:0] RST_FONT_WIDTH = 4'd5;
    localparam logic [2:0] RST_FONT_PAGES = 3'd1;
    localparam logic [7:0] RST_FIRST_CODE = 8'd32;

    // LCD command bases
    localparam logic [7:0] CMD_ROW = 8'h40;
    localparam logic [7:0] CMD_COL = 8'h80;

    // Glyph block layout: header bytes before block 0, skip to first column
    localparam int HEADER_BYTES = 5;
    localparam int GLYPH_SKIP   = 2;

    localparam logic [2:0] INIT_LAST_IDX = 3'd5;

    // Source of the next output word
    typedef enum logic [2:0] {
        K_INIT     = 3'd0,
        K_ROW_BASE = 3'd1,
        K_ROW_PAGE = 3'd2,
        K_COL      = 3'd3,
        K_DATA     = 3'd4
    } out_kind_t;

    typedef struct packed {
        logic      accept;
        logic      calc;
        logic      rd_width;
        logic      cap_width;
        logic      emit;
        out_kind_t kind;
        logic      last;
        logic      step_init;
        logic      step_data;
        logic      next_page;
        logic      finish_draw;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic init_last;
        logic width_zero;
        logic pages_zero;
        logic page_last;
        logic cnt_last;
    } ctrl_sts_t;

    // Start-up command sequence
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h21;
            3'd1:    b = 8'hC0;
            3'd2:    b = 8'h07;
            3'd3:    b = 8'h13;
            3'd4:    b = 8'h20;
            3'd5:    b = 8'h0C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== src/bftr_ctrl.sv =====
module bftr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bftr_pkg::op_t       in_op,
    input  bftr_pkg::ctrl_sts_t sts,
    output bftr_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_INIT    = 10'b00_0000_0010,
        ST_CALC    = 10'b00_0000_0100,
        ST_RDW     = 10'b00_0000_1000,
        ST_CAPW    = 10'b00_0001_0000,
        ST_CUR_ROW = 10'b00_0010_0000,
        ST_CUR_COL = 10'b00_0100_0000,
        ST_PG_ROW  = 10'b00_1000_0000,
        ST_PG_COL  = 10'b01_0000_0000,
        ST_PG_DATA = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer: one output word per cycle while the output slot is free
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.kind      = bftr_pkg::K_INIT;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (in_op == bftr_pkg::OP_INIT) begin
                        state_next = ST_INIT;
                    end else if (in_op == bftr_pkg::OP_DRAW) begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_INIT: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.kind      = bftr_pkg::K_INIT;
                    cmd.step_init = 1'b1;
                    cmd.last      = sts.init_last;
                    if (sts.init_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_RDW;
            end
            ST_RDW: begin
                cmd.rd_width = 1'b1;
                state_next   = ST_CAPW;
            end
            ST_CAPW: begin
                cmd.cap_width = 1'b1;
                state_next    = ST_CUR_ROW;
            end
            ST_CUR_ROW: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = bftr_pkg::K_ROW_BASE;
                    state_next = ST_CUR_COL;
                end
            end
            ST_CUR_COL: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = bftr_pkg::K_COL;
                    if (sts.pages_zero) begin
                        cmd.last        = 1'b1;
                        cmd.finish_draw = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        state_next = ST_PG_ROW;
                    end
                end
            end
            ST_PG_ROW: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = bftr_pkg::K_ROW_PAGE;
                    state_next = ST_PG_COL;
                end
            end
            ST_PG_COL: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = bftr_pkg::K_COL;
                    if (!sts.width_zero) begin
                        state_next = ST_PG_DATA;
                    end else if (sts.page_last) begin
                        cmd.last        = 1'b1;
                        cmd.finish_draw = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        cmd.next_page = 1'b1;
                        state_next    = ST_PG_ROW;
                    end
                end
            end
            ST_PG_DATA: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.kind      = bftr_pkg::K_DATA;
                    cmd.step_data = 1'b1;
                    if (sts.cnt_last) begin
                        if (sts.page_last) begin
                            cmd.last        = 1'b1;
                            cmd.finish_draw = 1'b1;
                            state_next      = ST_IDLE;
                        end else begin
                            cmd.next_page = 1'b1;
                            state_next    = ST_PG_ROW;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/bftr_datapath.sv =====
module bftr_datapath #(
    parameter int TABLE_BYTES    = 4096,
    parameter int MAX_FONT_WIDTH = 12,
    parameter int MAX_FONT_PAGES = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  bftr_pkg::op_t       in_op,
    input  logic [11:0]         in_table_address,
    input  logic [7:0]          in_table_byte,
    input  logic [7:0]          in_char_code,
    input  logic [6:0]          in_start_column,
    input  logic [2:0]          in_start_row,
    input  bftr_pkg::ctrl_cmd_t cmd,
    output bftr_pkg::ctrl_sts_t sts,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [7:0]          m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    localparam int ADDR_W = $clog2(TABLE_BYTES);

    // Font table, contents undefined until loaded
    logic [7:0] mem [TABLE_BYTES];

    logic [3:0]        font_width_reg;
    logic [2:0]        font_pages_reg;
    logic [7:0]        first_code_reg;
    logic [7:0]        col_reg;
    logic [2:0]        row_reg;
    logic [7:0]        code_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [7:0]        gw_reg;
    logic [7:0]        rd_reg;
    logic [5:0]        run_reg;
    logic [5:0]        run_next;
    logic [2:0]        page_reg;
    logic [3:0]        cnt_reg;
    logic [2:0]        idx_reg;
    logic              m_valid_reg;
    logic [7:0]        m_data_reg;
    logic              m_user_reg;
    logic              m_last_reg;

    logic [3:0]        w_sat;
    logic [2:0]        p_sat;
    logic [4:0]        stride;
    logic signed [8:0] diff;
    logic signed [14:0] prod;
    logic signed [14:0] base_sum;
    logic [ADDR_W+14:0] base_ext;
    logic [ADDR_W+11:0] load_ext;
    logic [ADDR_W-1:0]  load_addr;
    logic [ADDR_W-1:0]  data_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [2:0]         page_row;
    logic [7:0]         out_byte;
    logic               load_wr;

    // Saturated font geometry
    assign w_sat = (font_width_reg > 4'(MAX_FONT_WIDTH)) ? 4'(MAX_FONT_WIDTH) : font_width_reg;
    assign p_sat = (font_pages_reg > 3'(MAX_FONT_PAGES)) ? 3'(MAX_FONT_PAGES) : font_pages_reg;

    // Glyph block base: (code - first) * (W + 1) * 2 + header, wrapped to the table
    assign stride   = {w_sat + 4'd1, 1'b0};
    assign diff     = $signed({1'b0, code_reg}) - $signed({1'b0, first_code_reg});
    assign prod     = diff * $signed({1'b0, stride});
    assign base_sum = prod + 15'(bftr_pkg::HEADER_BYTES);
    assign base_ext = {{ADDR_W{base_sum[14]}}, base_sum};

    assign load_ext  = {{ADDR_W{1'b0}}, in_table_address};
    assign load_addr = load_ext[ADDR_W-1:0];
    assign load_wr   = cmd.accept && (in_op == bftr_pkg::OP_LOAD);

    // Read address runs one word ahead so rd_reg always holds the current column
    assign run_next  = cmd.step_data ? run_reg + 6'd1 : run_reg;
    assign data_addr = base_reg + ADDR_W'(bftr_pkg::GLYPH_SKIP) + ADDR_W'(run_next);
    assign rd_addr   = cmd.rd_width ? base_reg : data_addr;

    // Table port: one write, one registered read
    always_ff @(posedge aclk) begin
        if (load_wr) begin
            mem[load_addr] <= in_table_byte;
        end
        rd_reg <= mem[rd_addr];
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            font_width_reg <= bftr_pkg::RST_FONT_WIDTH;
            font_pages_reg <= bftr_pkg::RST_FONT_PAGES;
            first_code_reg <= bftr_pkg::RST_FIRST_CODE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bftr_pkg::CFG_FONT_WIDTH: font_width_reg <= cfg_data[3:0];
                bftr_pkg::CFG_FONT_PAGES: font_pages_reg <= cfg_data[2:0];
                bftr_pkg::CFG_FIRST_CODE: first_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Text cursor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.accept && (in_op == bftr_pkg::OP_CURSOR)) begin
            col_reg <= {1'b0, in_start_column};
            row_reg <= in_start_row;
        end else if (cmd.finish_draw) begin
            col_reg <= col_reg + gw_reg + 8'd1;
        end
    end

    // Per-item counters and glyph base
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= '0;
            page_reg <= '0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
        end else if (cmd.accept) begin
            run_reg  <= '0;
            page_reg <= '0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
        end else begin
            run_reg <= run_next;
            if (cmd.step_init) begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (cmd.next_page) begin
                page_reg <= page_reg + 3'd1;
                cnt_reg  <= '0;
            end else if (cmd.step_data) begin
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            code_reg <= in_char_code;
        end
        if (cmd.calc) begin
            base_reg <= base_ext[ADDR_W-1:0];
        end
        if (cmd.cap_width) begin
            gw_reg <= rd_reg;
        end
    end

    // Output word select
    assign page_row = row_reg + page_reg;

    always_comb begin
        case (cmd.kind)
            bftr_pkg::K_INIT:     out_byte = bftr_pkg::init_byte(idx_reg);
            bftr_pkg::K_ROW_BASE: out_byte = bftr_pkg::CMD_ROW | {5'd0, row_reg};
            bftr_pkg::K_ROW_PAGE: out_byte = bftr_pkg::CMD_ROW | {5'd0, page_row};
            bftr_pkg::K_COL:      out_byte = bftr_pkg::CMD_COL | col_reg;
            bftr_pkg::K_DATA:     out_byte = rd_reg;
            default:              out_byte = rd_reg;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= out_byte;
            m_user_reg <= (cmd.kind == bftr_pkg::K_DATA);
            m_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // Status to the sequencer
    assign sts.out_free   = !m_valid_reg || m_tready;
    assign sts.init_last  = (idx_reg == bftr_pkg::INIT_LAST_IDX);
    assign sts.width_zero = (w_sat == 4'd0);
    assign sts.pages_zero = (p_sat == 3'd0);
    assign sts.page_last  = (page_reg == p_sat - 3'd1);
    assign sts.cnt_last   = (cnt_reg == w_sat - 4'd1);

endmodule

// ===== src/bitmap_font_text_renderer_top.sv =====
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_tvalid/s_tready  | tuser: operation; tdata: table word, code, cursor
// m_      | out | m_tvalid/m_tready  | tdata: LCD byte; tuser: data flag; tlast: last byte
// cfg_    | in  | cfg_wr_en          | cfg_index selects, cfg_data written
//
// Load and set cursor leave the input ready. Init gives 6 words, one a cycle
// while m_tready allows. Draw: accept, base multiply, width read, capture, then
// 2 + P*(2 + W) words, one a cycle while m_tready allows, data from the read port.
// Reset clears cursor, output valid and restores the font registers; the
// font table is not cleared. m_tready low holds the word and the next word out.
module bitmap_font_text_renderer_top #(
    parameter int TABLE_BYTES    = 4096,
    parameter int MAX_FONT_WIDTH = 12,
    parameter int MAX_FONT_PAGES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // table_address[11:0], table_byte[19:12],
                                   // char_code[27:20], start_column[34:28],
                                   // start_row[37:35], zero pad
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tuser,   // is_data[0]
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    bftr_pkg::ctrl_cmd_t cmd;
    bftr_pkg::ctrl_sts_t sts;
    bftr_pkg::op_t       in_op;

    assign in_op = bftr_pkg::op_t'(s_tuser);

    bftr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (in_op),
        .sts      (sts),
        .cmd      (cmd)
    );

    bftr_datapath #(
        .TABLE_BYTES    (TABLE_BYTES),
        .MAX_FONT_WIDTH (MAX_FONT_WIDTH),
        .MAX_FONT_PAGES (MAX_FONT_PAGES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_op            (in_op),
        .in_table_address (s_tdata[11:0]),
        .in_table_byte    (s_tdata[19:12]),
        .in_char_code     (s_tdata[27:20]),
        .in_start_column  (s_tdata[34:28]),
        .in_start_row     (s_tdata[37:35]),
        .cmd              (cmd),
        .sts              (sts),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast)
    );

endmodule

// ===== src/bftr_checker.sv =====
`include "bitmap_font_text_renderer_top_macros.svh"

module bftr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // A stalled word holds
    `BFTR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // Command words are cursor row, cursor column or start-up codes
    `BFTR_ASSERT_NOW(a_cmd_form, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[7] || (m_tdata[7:3] == 5'b01000) || m_tdata == 8'h21 || m_tdata == 8'h07 || m_tdata == 8'h13 || m_tdata == 8'h20 || m_tdata == 8'h0C)

    // Draw and init busy the input side the cycle after they are taken
    `BFTR_ASSERT_NEXT(a_busy_after_draw, aclk, aresetn, s_tvalid && s_tready && s_tuser[1], !s_tready)

    // No new item while a sequence is half delivered
    `BFTR_ASSERT_NOW(a_no_accept_mid_seq, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)

endmodule

bind bitmap_font_text_renderer_top bftr_checker u_bftr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
